// ===== sv/crld_pkg.sv =====
// ============================================================================
// crld_pkg: shared types and constants of the cluster run list decoder
// Holds result kinds, parser phases, register indexes and the structs passed
// between the configuration, step and output modules.
// ============================================================================
package crld_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned SIZE_W = 4;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned LOG2_W = 5;
   localparam logic [LOG2_W-1:0] LOG2_RESET = 5'd12;

   typedef enum logic [1:0] {
      KIND_RUN   = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_LENGTH = 4'b0100,
      PH_OFFSET = 4'b1000
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_VCN    = 2'd0,
      CSR_VALID_LENGTH = 2'd1,
      CSR_CLUSTER_LOG2 = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic [WORD_W-1:0] start_vcn;
      logic [WORD_W-1:0] valid_length;
      logic [WORD_W-1:0] cluster_limit;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] vcn;
      logic [WORD_W-1:0] lcn;
      logic [WORD_W-1:0] length;
      logic              sparse;
      logic              last;
   } result_type;

endpackage

// ===== sv/cluster_run_list_decoder_core.sv =====
// ============================================================================
// cluster_run_list_decoder_core: mapping-pairs run list decoder
// Turns an encoded run list, one byte per transfer, into run records.
// ============================================================================
// Usage:
//   The req_ stream carries one byte of the encoded run list per transfer;
//   req_tuser marks the first header byte of a list and restarts the parser.
//   The rsp_ stream returns at most one result per byte: a run record, an
//   end-of-list mark or a malformed-header error, with rsp_tlast set on the
//   result that closes the list. The csr_ port writes the start VCN, the
//   valid length and the cluster size; write them only between lists.
//   A byte is held in the input register and decoded in a single pass into
//   the result register, which drives rsp_tvalid. One byte is taken every
//   cycle unless a result waits on a stalled receiver; the field gather,
//   one 64-bit add and a compare set the critical path.
//   While the receiver stalls, the result register holds its entry and
//   bytes that yield no result keep flowing; a byte that yields a result
//   waits in the input register and req_tready drops behind it.
//   Reset empties both registers and leaves the parser outside any list.
// ============================================================================
module cluster_run_list_decoder_core #(
   parameter int unsigned MAX_FIELD_BYTES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: data_byte[7:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // tuser: first[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: run_vcn[63:0], run_lcn[127:64], run_length[191:128]
   output logic [191:0]                       rsp_tdata,
   // tuser: kind[1:0], sparse[2]
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crld_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [crld_pkg::WORD_W-1:0]        csr_wdata
);

   crld_pkg::cfg_type      cfg;
   crld_pkg::result_type   res;
   logic                   res_push;
   logic                   out_free;

   crld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crld_step #(
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_byte  (req_tdata),
      .req_first (req_tuser),
      .cfg       (cfg),
      .out_free  (out_free),
      .res_push  (res_push),
      .res       (res)
   );

   crld_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_push   (res_push),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/crld_csr.sv =====
// ============================================================================
// crld_csr: configuration registers
// Holds the start VCN, valid length and cluster size, and derives the cluster
// limit as the valid length divided by the cluster size, rounded up.
// ============================================================================
module crld_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crld_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [crld_pkg::WORD_W-1:0]         csr_wdata,
   output crld_pkg::cfg_type                   cfg
);

   logic [crld_pkg::WORD_W-1:0] start_vcn_ff;
   logic [crld_pkg::WORD_W-1:0] valid_len_ff;
   logic [crld_pkg::LOG2_W-1:0] log2_ff;
   logic [crld_pkg::WORD_W-1:0] shifted;
   logic [crld_pkg::WORD_W-1:0] low_mask;
   logic                        round_up;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_vcn_ff <= '0;
         valid_len_ff <= '0;
         log2_ff      <= crld_pkg::LOG2_RESET;
      end else if (csr_valid) begin
         case (csr_addr)
            crld_pkg::CSR_START_VCN:    start_vcn_ff <= csr_wdata;
            crld_pkg::CSR_VALID_LENGTH: valid_len_ff <= csr_wdata;
            crld_pkg::CSR_CLUSTER_LOG2: log2_ff <= csr_wdata[crld_pkg::LOG2_W-1:0];
            default: ;
         endcase
      end
   end

   // Ceiling division by a power of two: shift, then add one if any
   // remainder bit is set.
   always_comb begin
      shifted  = valid_len_ff >> log2_ff;
      low_mask = (64'd1 << log2_ff) - 64'd1;
      round_up = |(valid_len_ff & low_mask);
   end

   assign cfg.start_vcn     = start_vcn_ff;
   assign cfg.valid_length  = valid_len_ff;
   assign cfg.cluster_limit = shifted + {63'd0, round_up};

endmodule

// ===== sv/crld_step.sv =====
// ============================================================================
// crld_step: input register and run list parser
// Registers each incoming byte, then in one pass decodes headers, gathers
// length and offset fields, and updates the run position and LCN sum.
// ============================================================================
module crld_step #(
   parameter int unsigned MAX_FIELD_BYTES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_byte,
   input  logic                         req_first,
   input  crld_pkg::cfg_type            cfg,
   input  logic                         out_free,
   output logic                         res_push,
   output crld_pkg::result_type         res
);

   localparam int unsigned ACC_W = 8 * MAX_FIELD_BYTES;
   localparam int unsigned BC_W  = $clog2(MAX_FIELD_BYTES + 1);
   localparam logic [crld_pkg::SIZE_W-1:0] MAX_SIZE = crld_pkg::SIZE_W'(MAX_FIELD_BYTES);

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [7:0]                     in_byte_ff;
   logic                           in_first_ff;

   crld_pkg::phase_type            phase_ff, phase_in;
   logic [crld_pkg::SIZE_W-1:0]    len_size_ff, len_size_in;
   logic [crld_pkg::SIZE_W-1:0]    off_size_ff, off_size_in;
   logic [BC_W-1:0]                bcount_ff, bcount_in;
   logic [ACC_W-1:0]               acc_ff, acc_in;
   logic [crld_pkg::WORD_W-1:0]    run_start_ff, run_start_in;
   logic [crld_pkg::WORD_W-1:0]    next_ff, next_in;
   logic [crld_pkg::WORD_W-1:0]    lcn_ff, lcn_in;
   logic [crld_pkg::WORD_W-1:0]    limit_ff, limit_in;

   crld_pkg::phase_type            eff_phase;
   logic [ACC_W-1:0]               field_now;
   logic [crld_pkg::SIZE_W-1:0]    bcount_inc;
   logic [crld_pkg::SIZE_W-1:0]    hdr_len;
   logic [crld_pkg::SIZE_W-1:0]    hdr_off;
   logic [crld_pkg::WORD_W-1:0]    len_ext;
   logic [crld_pkg::WORD_W-1:0]    off_ext;
   logic                           over;
   logic                           produce;
   logic                           advance;

   // Sign extension of a field of n bytes (1 to MAX_FIELD_BYTES) to 64 bits.
   function automatic logic [crld_pkg::WORD_W-1:0] sext_field(
      input logic [ACC_W-1:0]              f,
      input logic [crld_pkg::SIZE_W-1:0]   n
   );
      logic                                 sign;
      logic [ACC_W-1:0]                     r;
      logic [crld_pkg::WORD_W+ACC_W-1:0]    w;
      sign = 1'b0;
      r    = f;
      for (int k = 0; k < int'(MAX_FIELD_BYTES); k++) begin
         if (n == crld_pkg::SIZE_W'(k + 1)) sign = f[8*k+7];
      end
      for (int k = 0; k < int'(MAX_FIELD_BYTES); k++) begin
         if (crld_pkg::SIZE_W'(k) >= n) r[8*k +: 8] = {8{sign}};
      end
      w = {{crld_pkg::WORD_W{sign}}, r};
      return w[crld_pkg::WORD_W-1:0];
   endfunction

   // ---------------------------------------------------------------- parser
   always_comb begin
      eff_phase    = in_first_ff ? crld_pkg::PH_HEADER : phase_ff;
      phase_in     = eff_phase;
      len_size_in  = in_first_ff ? '0 : len_size_ff;
      off_size_in  = in_first_ff ? '0 : off_size_ff;
      bcount_in    = in_first_ff ? '0 : bcount_ff;
      acc_in       = in_first_ff ? '0 : acc_ff;
      run_start_in = in_first_ff ? cfg.start_vcn : run_start_ff;
      next_in      = in_first_ff ? cfg.start_vcn : next_ff;
      lcn_in       = in_first_ff ? '0 : lcn_ff;
      limit_in     = in_first_ff ? cfg.cluster_limit : limit_ff;

      field_now = acc_ff;
      for (int k = 0; k < int'(MAX_FIELD_BYTES); k++) begin
         if (bcount_ff == BC_W'(k)) field_now[8*k +: 8] = acc_ff[8*k +: 8] | in_byte_ff;
      end
      bcount_inc = crld_pkg::SIZE_W'(bcount_ff) + 4'd1;
      hdr_len    = in_byte_ff[3:0];
      hdr_off    = in_byte_ff[7:4];
      len_ext    = sext_field(field_now, len_size_ff);
      off_ext    = sext_field(field_now, off_size_ff);
      over       = next_ff > limit_ff;

      produce    = 1'b0;
      res.kind   = crld_pkg::KIND_END;
      res.vcn    = next_in;
      res.lcn    = '0;
      res.length = '0;
      res.sparse = 1'b0;
      res.last   = 1'b1;

      if (in_first_ff && (cfg.valid_length == '0)) begin
         // An empty limit closes the list before the header is looked at.
         produce  = 1'b1;
         phase_in = crld_pkg::PH_IDLE;
      end else begin
         case (eff_phase)
            crld_pkg::PH_HEADER: begin
               if (in_byte_ff == 8'd0) begin
                  produce  = 1'b1;
                  phase_in = crld_pkg::PH_IDLE;
               end else if ((hdr_len == '0) || (hdr_len > MAX_SIZE) ||
                            (hdr_off > MAX_SIZE)) begin
                  produce  = 1'b1;
                  res.kind = crld_pkg::KIND_ERROR;
                  phase_in = crld_pkg::PH_IDLE;
               end else begin
                  len_size_in = hdr_len;
                  off_size_in = hdr_off;
                  bcount_in   = '0;
                  acc_in      = '0;
                  phase_in    = crld_pkg::PH_LENGTH;
               end
            end
            crld_pkg::PH_LENGTH: begin
               if (bcount_inc < len_size_ff) begin
                  bcount_in = BC_W'(bcount_inc);
                  acc_in    = field_now;
               end else begin
                  run_start_in = next_ff;
                  next_in      = next_ff + len_ext;
                  bcount_in    = '0;
                  acc_in       = '0;
                  if (off_size_ff == '0) begin
                     // Sparse run: no clamp, but it may still end the list.
                     produce    = 1'b1;
                     res.kind   = crld_pkg::KIND_RUN;
                     res.vcn    = next_ff;
                     res.length = len_ext;
                     res.sparse = 1'b1;
                     res.last   = (len_ext == (limit_ff - next_ff));
                     phase_in   = res.last ? crld_pkg::PH_IDLE : crld_pkg::PH_HEADER;
                  end else begin
                     phase_in = crld_pkg::PH_OFFSET;
                  end
               end
            end
            crld_pkg::PH_OFFSET: begin
               if (bcount_inc < off_size_ff) begin
                  bcount_in = BC_W'(bcount_inc);
                  acc_in    = field_now;
               end else begin
                  lcn_in     = lcn_ff + off_ext;
                  bcount_in  = '0;
                  acc_in     = '0;
                  next_in    = over ? limit_ff : next_ff;
                  produce    = 1'b1;
                  res.kind   = crld_pkg::KIND_RUN;
                  res.vcn    = run_start_ff;
                  res.lcn    = lcn_ff + off_ext;
                  res.length = over ? (limit_ff - run_start_ff) : (next_ff - run_start_ff);
                  res.last   = (next_ff >= limit_ff);
                  phase_in   = res.last ? crld_pkg::PH_IDLE : crld_pkg::PH_HEADER;
               end
            end
            default: begin
               // Idle: bytes outside a list are dropped.
               produce = 1'b0;
            end
         endcase
      end
   end

   // The held byte moves on when it yields nothing or the result slot frees up.
   assign advance     = in_valid_ff && (!produce || out_free);
   assign res_push    = advance && produce;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_byte;
         in_first_ff <= req_first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crld_pkg::PH_IDLE;
         len_size_ff  <= '0;
         off_size_ff  <= '0;
         bcount_ff    <= '0;
         acc_ff       <= '0;
         run_start_ff <= '0;
         next_ff      <= '0;
         lcn_ff       <= '0;
         limit_ff     <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         len_size_ff  <= len_size_in;
         off_size_ff  <= off_size_in;
         bcount_ff    <= bcount_in;
         acc_ff       <= acc_in;
         run_start_ff <= run_start_in;
         next_ff      <= next_in;
         lcn_ff       <= lcn_in;
         limit_ff     <= limit_in;
      end
   end

endmodule

// ===== sv/crld_out.sv =====
// ============================================================================
// crld_out: result register
// Holds one result until the receiver takes it and maps it onto the
// result stream ports.
// ============================================================================
module crld_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         res_push,
   input  crld_pkg::result_type         res,
   output logic                         out_free,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [191:0]                 rsp_tdata,
   output logic [2:0]                   rsp_tuser,
   output logic                         rsp_tlast
);

   logic                   valid_ff;
   logic                   valid_in;
   crld_pkg::result_type   res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = res_push || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.length, res_ff.lcn, res_ff.vcn};
   assign rsp_tuser  = {res_ff.sparse, res_ff.kind};
   assign rsp_tlast  = res_ff.last;

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// tb: self-checking bench for the cluster run list decoder
// Streams encoded run lists into the core: a short directed set, then random
// lists under changing register settings. A built-in decoder predicts every
// run record, end mark and header error; results are checked in order.
// ============================================================================
module tb;

   localparam int unsigned MAX_FIELD = 8;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned CHOKE_AT = 300;
   localparam int unsigned CHOKE_CYCLES = 400;
   localparam int unsigned BYTE_TARGET = 800;

   typedef enum logic [1:0] {
      STEP_BYTE,
      STEP_WRITE,
      STEP_DRAIN
   } step_type;

   typedef struct {
      step_type               what;
      logic [7:0]             data;
      logic                   is_first;
      crld_pkg::csr_addr_type addr;
      logic [63:0]            wdata;
   } plan_item_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [191:0]                    rsp_tdata;
   logic [2:0]                      rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [crld_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [crld_pkg::WORD_W-1:0]     csr_wdata = '0;

   cluster_run_list_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Decoder state mirrored by the bench.
   logic [63:0]         cfg_start_vcn = '0;
   logic [63:0]         cfg_valid_length = '0;
   logic [4:0]          cfg_cluster_log2 = crld_pkg::LOG2_RESET;
   crld_pkg::phase_type parse_phase = crld_pkg::PH_IDLE;
   logic [3:0]          len_size = '0;
   logic [3:0]          off_size = '0;
   logic [3:0]          field_bytes = '0;
   logic [63:0]         field_acc = '0;
   logic [63:0]         run_first_vcn = '0;
   logic [63:0]         vcn_cursor = '0;
   logic [63:0]         lcn_sum = '0;
   logic [63:0]         vcn_limit = '0;

   crld_pkg::result_type expected_runs[$];
   plan_item_type        byte_plan[$];
   int unsigned          byte_total = 0;
   int unsigned          bytes_taken = 0;
   int unsigned          mismatches = 0;
   int unsigned          quiet_cycles = 0;

   logic        req_fire = 1'b0;
   logic        rsp_fire = 1'b0;
   logic        csr_fire = 1'b0;
   logic        plan_done = 1'b0;
   logic        send_eager = 1'b0;
   logic        take_eager = 1'b0;
   logic        choke_done = 1'b0;
   int unsigned choke_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned settle_left = SETTLE_CYCLES;

   function automatic logic [63:0] widen_signed(logic [63:0] v, logic [3:0] nbytes);
      logic [63:0] mask;
      if (nbytes == 0 || nbytes >= 8)
         return v;
      mask = (64'd1 << (nbytes * 8)) - 64'd1;
      v &= mask;
      if (v[nbytes*8-1])
         v |= ~mask;
      return v;
   endfunction

   function automatic void post_result(crld_pkg::kind_type k, logic [63:0] vcn,
                                       logic [63:0] lcn, logic [63:0] len,
                                       logic sp, logic fin);
      crld_pkg::result_type r;
      r.kind = k;
      r.vcn = vcn;
      r.lcn = lcn;
      r.length = len;
      r.sparse = sp;
      r.last = fin;
      expected_runs.push_back(r);
   endfunction

   function automatic void emit_run(logic [63:0] lcn, logic sp);
      logic fin;
      fin = (vcn_cursor == vcn_limit);
      post_result(crld_pkg::KIND_RUN, run_first_vcn, lcn, vcn_cursor - run_first_vcn,
                  sp, fin);
      parse_phase = fin ? crld_pkg::PH_IDLE : crld_pkg::PH_HEADER;
   endfunction

   // Advances the mirrored parser by one byte and queues any result it gives.
   function automatic void decode_byte(logic [7:0] b, logic is_first);
      logic [63:0] lim;
      if (is_first) begin
         lim = cfg_valid_length >> cfg_cluster_log2;
         if ((cfg_valid_length & ((64'd1 << cfg_cluster_log2) - 64'd1)) != 0)
            lim += 64'd1;
         vcn_limit = lim;
         vcn_cursor = cfg_start_vcn;
         run_first_vcn = cfg_start_vcn;
         lcn_sum = '0;
         len_size = '0;
         off_size = '0;
         field_bytes = '0;
         field_acc = '0;
         if (vcn_limit == 0) begin
            parse_phase = crld_pkg::PH_IDLE;
            post_result(crld_pkg::KIND_END, vcn_cursor, '0, '0, 1'b0, 1'b1);
            return;
         end
         parse_phase = crld_pkg::PH_HEADER;
      end
      case (parse_phase)
         crld_pkg::PH_HEADER: begin
            if (b == 8'h00) begin
               parse_phase = crld_pkg::PH_IDLE;
               post_result(crld_pkg::KIND_END, vcn_cursor, '0, '0, 1'b0, 1'b1);
               return;
            end
            len_size = b[3:0];
            off_size = b[7:4];
            if (len_size == 0 || len_size > MAX_FIELD || off_size > MAX_FIELD) begin
               parse_phase = crld_pkg::PH_IDLE;
               post_result(crld_pkg::KIND_ERROR, vcn_cursor, '0, '0, 1'b0, 1'b1);
               return;
            end
            field_bytes = '0;
            field_acc = '0;
            parse_phase = crld_pkg::PH_LENGTH;
         end
         crld_pkg::PH_LENGTH: begin
            field_acc |= {56'd0, b} << (field_bytes[2:0] * 8);
            field_bytes += 4'd1;
            if (field_bytes < len_size)
               return;
            run_first_vcn = vcn_cursor;
            vcn_cursor += widen_signed(field_acc, len_size);
            field_bytes = '0;
            field_acc = '0;
            if (off_size == 0)
               emit_run('0, 1'b1);
            else
               parse_phase = crld_pkg::PH_OFFSET;
         end
         crld_pkg::PH_OFFSET: begin
            field_acc |= {56'd0, b} << (field_bytes[2:0] * 8);
            field_bytes += 4'd1;
            if (field_bytes < off_size)
               return;
            lcn_sum += widen_signed(field_acc, off_size);
            field_bytes = '0;
            field_acc = '0;
            if (vcn_cursor > vcn_limit)
               vcn_cursor = vcn_limit;
            emit_run(lcn_sum, 1'b0);
         end
         default: ;
      endcase
   endfunction

   task automatic plan_byte(logic [7:0] b, logic is_first);
      plan_item_type p;
      p.what = STEP_BYTE;
      p.data = b;
      p.is_first = is_first;
      p.addr = crld_pkg::CSR_START_VCN;
      p.wdata = '0;
      byte_plan.push_back(p);
      byte_total++;
   endtask

   task automatic plan_write(crld_pkg::csr_addr_type a, logic [63:0] v);
      plan_item_type p;
      p.what = STEP_WRITE;
      p.data = '0;
      p.is_first = 1'b0;
      p.addr = a;
      p.wdata = v;
      byte_plan.push_back(p);
   endtask

   task automatic plan_drain();
      plan_item_type p;
      p.what = STEP_DRAIN;
      p.data = '0;
      p.is_first = 1'b0;
      p.addr = crld_pkg::CSR_START_VCN;
      p.wdata = '0;
      byte_plan.push_back(p);
   endtask

   // One header with its fields; a cut run stops somewhere inside its fields.
   task automatic plan_run(logic is_first, bit cut);
      logic [3:0]  nlen, noff;
      logic [7:0]  b;
      bit          short_len;
      int unsigned keep;
      nlen = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(1, 2));
      if ($urandom_range(0, 4) == 0)
         noff = 4'd0;
      else if ($urandom_range(0, 5) == 0)
         noff = 4'($urandom_range(1, 8));
      else
         noff = 4'($urandom_range(1, 3));
      short_len = ($urandom_range(0, 3) != 0);
      plan_byte({noff, nlen}, is_first);
      keep = cut ? $urandom_range(0, nlen + noff - 1) : nlen + noff;
      for (int unsigned j = 0; j < keep; j++) begin
         if (j < nlen && short_len)
            b = (j == 0) ? 8'($urandom_range(1, 60)) : 8'h00;
         else
            b = 8'($urandom);
         plan_byte(b, 1'b0);
      end
   endtask

   task automatic plan_list(bit broken);
      int unsigned runs, stop_at;
      logic [7:0]  hdr;
      runs = $urandom_range(1, 6);
      stop_at = broken ? $urandom_range(0, runs - 1) : runs;
      for (int unsigned i = 0; i < runs; i++) begin
         if (i == stop_at) begin
            if ($urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 2))
                  0: hdr = {4'($urandom_range(0, 8)), 4'h0};
                  1: hdr = {4'($urandom_range(0, 8)), 4'($urandom_range(9, 15))};
                  default: hdr = {4'($urandom_range(9, 15)), 4'($urandom_range(1, 15))};
               endcase
               plan_byte(hdr, i == 0);
            end else begin
               plan_run(i == 0, 1'b1);
            end
            return;
         end
         plan_run(i == 0, 1'b0);
      end
      if ($urandom_range(0, 9) != 0)
         plan_byte(8'h00, 1'b0);
   endtask

   // The first settings force the shift extremes; later ones are random.
   task automatic plan_settings(int unsigned k);
      logic [4:0]  lg;
      logic [63:0] vlen, vcn0;
      int unsigned clusters;
      case (k)
         0: lg = 5'd9;
         1: lg = 5'd21;
         2: lg = 5'd0;
         3: lg = 5'd31;
         default: lg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(9, 21));
      endcase
      clusters = $urandom_range(1, 200);
      case ($urandom_range(0, 9))
         0: vlen = '0;
         1: vlen = '1;
         2: vlen = {$urandom, $urandom};
         default: vlen = (64'(clusters) << lg) - ({$urandom, $urandom} % (64'd1 << lg));
      endcase
      case ((k == 3) ? 0 : $urandom_range(0, 7))
         0: vcn0 = '1;
         1: vcn0 = {$urandom, $urandom};
         default: vcn0 = 64'($urandom_range(0, 40));
      endcase
      plan_write(crld_pkg::CSR_CLUSTER_LOG2, {59'd0, lg});
      plan_write(crld_pkg::CSR_VALID_LENGTH, vlen);
      plan_write(crld_pkg::CSR_START_VCN, vcn0);
   endtask

   task automatic log_mismatch(string what, crld_pkg::result_type want,
                               crld_pkg::result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected kind=%0d vcn=%h lcn=%h len=%h sparse=%b last=%b,",
                  what, want.kind, want.vcn, want.lcn, want.length, want.sparse,
                  want.last);
         $display("   got kind=%0d vcn=%h lcn=%h len=%h sparse=%b last=%b",
                  got.kind, got.vcn, got.lcn, got.length, got.sparse, got.last);
      end
   endtask

   // Sender: bytes and register writes, with drawn gaps between bytes.
   always @(negedge clock) begin : sender
      plan_item_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
      end else if ((req_tvalid && !req_fire) || (csr_valid && !csr_fire)) begin
         // The offered transfer has not been taken yet.
      end else if (gap_left != 0) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (byte_plan.size() == 0) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         plan_done <= 1'b1;
      end else if (byte_plan[0].what != STEP_BYTE &&
                   (expected_runs.size() != 0 || settle_left != 0)) begin
         // Let the pipeline empty before a write or a drain marker.
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         settle_left <= (expected_runs.size() != 0) ? SETTLE_CYCLES : settle_left - 1;
      end else begin
         p = byte_plan.pop_front();
         if ($urandom_range(0, 49) == 0)
            send_eager <= !send_eager;
         case (p.what)
            STEP_BYTE: begin
               req_tvalid <= 1'b1;
               req_tdata <= p.data;
               req_tuser <= p.is_first;
               csr_valid <= 1'b0;
               settle_left <= SETTLE_CYCLES;
               gap_left <= send_eager ? 0 : $urandom_range(0, 17);
            end
            STEP_WRITE: begin
               req_tvalid <= 1'b0;
               csr_valid <= 1'b1;
               csr_addr <= p.addr;
               csr_wdata <= p.wdata;
            end
            default: begin
               req_tvalid <= 1'b0;
               csr_valid <= 1'b0;
            end
         endcase
      end
   end

   // Receiver: drawn stalls after each result, and one long hold-off.
   always @(negedge clock) begin : receiver
      int unsigned wait_draw;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!choke_done && bytes_taken >= CHOKE_AT) begin
         choke_done <= 1'b1;
         choke_left <= CHOKE_CYCLES;
         rsp_tready <= 1'b0;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_fire) begin
         if ($urandom_range(0, 29) == 0)
            take_eager <= !take_eager;
         wait_draw = take_eager ? 0 : $urandom_range(0, 17);
         stall_left <= wait_draw;
         rsp_tready <= (wait_draw == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      crld_pkg::result_type got;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         csr_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         csr_fire <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               crld_pkg::CSR_START_VCN:    cfg_start_vcn = csr_wdata;
               crld_pkg::CSR_VALID_LENGTH: cfg_valid_length = csr_wdata;
               crld_pkg::CSR_CLUSTER_LOG2: cfg_cluster_log2 = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = crld_pkg::kind_type'(rsp_tuser[1:0]);
            got.sparse = rsp_tuser[2];
            got.vcn = rsp_tdata[63:0];
            got.lcn = rsp_tdata[127:64];
            got.length = rsp_tdata[191:128];
            got.last = rsp_tlast;
            if (expected_runs.size() == 0)
               log_mismatch("unexpected result", '0, got);
            else if (expected_runs[0] !== got)
               log_mismatch("wrong result", expected_runs.pop_front(), got);
            else
               void'(expected_runs.pop_front());
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned lists, settings_no, pick;
      lists = 0;
      settings_no = 0;

      // Reset settings give an empty cluster limit; then a byte outside a list.
      plan_byte(8'h21, 1'b1);
      plan_byte(8'h5A, 1'b0);
      plan_write(crld_pkg::CSR_START_VCN, 64'd100);
      plan_write(crld_pkg::CSR_VALID_LENGTH, '1);
      plan_write(crld_pkg::CSR_CLUSTER_LOG2, 64'd12);
      // Restart inside a run, then a full run, a sparse run and the end mark.
      plan_byte(8'h21, 1'b1);
      plan_byte(8'h7F, 1'b0);
      plan_byte(8'h21, 1'b1);
      plan_byte(8'h7F, 1'b0);
      plan_byte(8'h34, 1'b0);
      plan_byte(8'h12, 1'b0);
      plan_byte(8'h01, 1'b0);
      plan_byte(8'h05, 1'b0);
      plan_byte(8'h00, 1'b0);
      // Malformed headers: no length field, oversized length, oversized offset.
      plan_byte(8'h10, 1'b1);
      plan_byte(8'h09, 1'b1);
      plan_byte(8'h91, 1'b1);
      // Full-width length of all ones and a negative one-byte offset.
      plan_byte(8'h18, 1'b1);
      repeat (8) plan_byte(8'hFF, 1'b0);
      plan_byte(8'h80, 1'b0);
      plan_byte(8'h00, 1'b0);

      plan_settings(settings_no++);
      while (byte_total < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            repeat ($urandom_range(1, 6)) plan_byte(8'($urandom), $urandom_range(0, 3) == 0);
         else
            plan_list(pick < 20);
         lists++;
         if (lists % 10 == 0)
            plan_settings(settings_no++);
         else if ($urandom_range(0, 15) == 0)
            plan_drain();
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!(plan_done && expected_runs.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
